FILE: rtl/core/frame_difference_foreground_mask_defines.svh
// assertion macros shared by the rtl files
`ifndef FRAME_DIFFERENCE_FOREGROUND_MASK_DEFINES_SVH
`define FRAME_DIFFERENCE_FOREGROUND_MASK_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define FDFM_ASSERT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("fdfm assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define FDFM_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("fdfm assertion failed");
`else
`define FDFM_ASSERT(name, pre, post)
`define FDFM_ASSERT_NXT(name, pre, post)
`endif

`endif

FILE: rtl/core/fdfm_pkg.sv
package fdfm_pkg;

  // pixel and frame store geometry
  localparam int PIX_W      = 8;
  localparam int MAX_PIXELS = 131072;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);

  // gray conversion: (1868*b + 9617*g + 4899*r + 8192) >> 14
  localparam int GRAY_SHIFT = 14;
  localparam int SUM_W      = GRAY_SHIFT + PIX_W;
  localparam logic [SUM_W-1:0] COEF_B    = SUM_W'(1868);
  localparam logic [SUM_W-1:0] COEF_G    = SUM_W'(9617);
  localparam logic [SUM_W-1:0] COEF_R    = SUM_W'(4899);
  localparam logic [SUM_W-1:0] GRAY_ROUND = SUM_W'(8192);

  localparam logic [PIX_W-1:0] WHITE = PIX_W'(255);

  // configuration register file
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_ADDR_W = CFG_IDX_W + 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [PIX_W-1:0] THRESH_MAX   = PIX_W'(250);
  localparam logic [PIX_W-1:0] THRESH_RESET = PIX_W'(5);

  // pixel leaving the gray stage
  typedef struct packed {
    logic [PIX_W-1:0]  blue;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  red;
    logic              eof;
    logic              first;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  gray;
  } s1_t;

endpackage

FILE: rtl/core/fdfm_pix_if.sv
interface fdfm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       end_of_frame;

  modport source (output valid, blue, green, red, end_of_frame, input ready);
  modport sink   (input valid, blue, green, red, end_of_frame, output ready);
endinterface

FILE: rtl/core/fdfm_res_if.sv
interface fdfm_res_if;
  logic       valid;
  logic       ready;
  logic       foreground;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic       frame_done;

  modport source (output valid, foreground, out_blue, out_green, out_red, frame_done,
                  input ready);
  modport sink   (input valid, foreground, out_blue, out_green, out_red, frame_done,
                  output ready);
endinterface

FILE: rtl/core/fdfm_ram.sv
module fdfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 131072,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port, read returns old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/fdfm_gray.sv
`include "frame_difference_foreground_mask_defines.svh"

module fdfm_gray (
  input  logic          clk,
  input  logic          rst_n,
  fdfm_pix_if.sink      in_pix,
  input  logic          s2_ready,
  output logic          s1_valid,
  output fdfm_pkg::s1_t s1
);
  import fdfm_pkg::*;

  logic              v1_r, v1_nxt;
  logic              ready1, accept;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              loading_r, loading_nxt;
  logic [PIX_W-1:0]  blue_r, green_r, red_r;
  logic              eof_r, first_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SUM_W-1:0]  pb_r, pg_r, pr_r;
  logic [SUM_W-1:0]  sum;

  assign ready1       = !v1_r || s2_ready;
  assign accept       = in_pix.valid && ready1;
  assign in_pix.ready = ready1;

  // stage valid and raster position tracking
  always_comb begin
    v1_nxt      = v1_r;
    pos_nxt     = pos_r;
    loading_nxt = loading_r;
    if (ready1) begin
      v1_nxt = in_pix.valid;
    end
    if (accept) begin
      if (in_pix.end_of_frame) begin
        pos_nxt     = '0;
        loading_nxt = 1'b0;
      end else if (pos_r == ADDR_W'(MAX_PIXELS - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      pos_r     <= '0;
      loading_r <= 1'b1;
    end else begin
      v1_r      <= v1_nxt;
      pos_r     <= pos_nxt;
      loading_r <= loading_nxt;
    end
  end

  // weighted color products, one multiplier per channel
  always_ff @(posedge clk) begin
    if (accept) begin
      blue_r  <= in_pix.blue;
      green_r <= in_pix.green;
      red_r   <= in_pix.red;
      eof_r   <= in_pix.end_of_frame;
      first_r <= loading_r;
      addr_r  <= pos_r;
      pb_r    <= COEF_B * SUM_W'(in_pix.blue);
      pg_r    <= COEF_G * SUM_W'(in_pix.green);
      pr_r    <= COEF_R * SUM_W'(in_pix.red);
    end
  end

  // rounded sum, top bits are the gray level
  assign sum = pb_r + pg_r + pr_r + GRAY_ROUND;

  assign s1_valid = v1_r;
  always_comb begin
    s1.blue  = blue_r;
    s1.green = green_r;
    s1.red   = red_r;
    s1.eof   = eof_r;
    s1.first = first_r;
    s1.addr  = addr_r;
    s1.gray  = sum[SUM_W-1:GRAY_SHIFT];
  end

  `FDFM_ASSERT_NXT(a_eof_restarts_frame, accept && in_pix.end_of_frame, (pos_r == '0) && !loading_r)
  `FDFM_ASSERT_NXT(a_loading_never_returns, !loading_r, !loading_r)

endmodule

FILE: rtl/core/fdfm_cmp.sv
`include "frame_difference_foreground_mask_defines.svh"

module fdfm_cmp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  input  fdfm_pkg::s1_t             s1,
  output logic                      s2_ready,
  input  logic [fdfm_pkg::PIX_W-1:0] threshold,
  fdfm_res_if.source                out_res
);
  import fdfm_pkg::*;

  logic              v2_r, v3_r;
  s1_t               s2_r;
  logic              ready2, ready3, load2, leave2;
  logic              fwd_hit_r;
  logic [PIX_W-1:0]  fwd_data_r;
  logic [PIX_W-1:0]  ram_rdata, prev_gray, diff;
  logic              fg;
  logic              fg_r, done_r;
  logic [PIX_W-1:0]  ob_r, og_r, or_r;

  assign ready3   = !v3_r || out_res.ready;
  assign ready2   = !v2_r || ready3;
  assign load2    = s1_valid && ready2;
  assign leave2   = v2_r && ready3;
  assign s2_ready = ready2;

  // previous frame gray levels, read on entry to stage 2, written on exit
  fdfm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (leave2),
    .waddr (s2_r.addr),
    .wdata (s2_r.gray),
    .re    (load2),
    .raddr (s1.addr),
    .rdata (ram_rdata)
  );

  // stage 2 register and write-to-read bypass for back-to-back same address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r      <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (ready2) begin
        v2_r <= s1_valid;
      end
      if (load2) begin
        fwd_hit_r <= leave2 && (s2_r.addr == s1.addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      s2_r       <= s1;
      fwd_data_r <= s2_r.gray;
    end
  end

  // absolute difference against threshold
  assign prev_gray = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign diff      = (s2_r.gray > prev_gray) ? (s2_r.gray - prev_gray)
                                             : (prev_gray - s2_r.gray);
  assign fg        = diff > threshold;

  // output register, first frame pixels produce no transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ready3) begin
      v3_r <= v2_r && !s2_r.first;
    end
  end

  always_ff @(posedge clk) begin
    if (leave2) begin
      fg_r   <= fg;
      ob_r   <= fg ? s2_r.blue  : WHITE;
      og_r   <= fg ? s2_r.green : WHITE;
      or_r   <= fg ? s2_r.red   : WHITE;
      done_r <= s2_r.eof;
    end
  end

  assign out_res.valid      = v3_r;
  assign out_res.foreground = fg_r;
  assign out_res.out_blue   = ob_r;
  assign out_res.out_green  = og_r;
  assign out_res.out_red    = or_r;
  assign out_res.frame_done = done_r;

  `FDFM_ASSERT_NXT(a_prev_held_in_stall, v2_r && !ready3, $stable(prev_gray))
  `FDFM_ASSERT_NXT(a_first_frame_silent, v2_r && s2_r.first && ready3, !v3_r)
  `FDFM_ASSERT_NXT(a_bypass_on_collision, load2 && leave2 && (s2_r.addr == s1.addr), fwd_hit_r)

endmodule

FILE: rtl/core/frame_difference_foreground_mask.sv
// channel   dir  handshake          payload
// in_pix    in   valid/ready        blue, green, red, end_of_frame
// out_res   out  valid/ready        foreground, out_blue, out_green, out_red, frame_done
// apb       in   psel/penable/...   threshold at byte address 0
//
// one pixel per clock sustained while out_res is ready, three register stages from input to result
// stage 1 multiplies and sums, stage 2 compares with the frame store, stage 3 drives out
// frame store has one read and one write port, each used once per pixel
// rst_n is synchronous; the store is not cleared, the first frame fills it silently
// each stage holds while the one ahead is full and stalled; bubbles close up
`include "frame_difference_foreground_mask_defines.svh"

module frame_difference_foreground_mask (
  input  logic                              clk,
  input  logic                              rst_n,
  fdfm_pix_if.sink                          in_pix,
  fdfm_res_if.source                        out_res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fdfm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fdfm_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fdfm_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import fdfm_pkg::*;

  logic                 s1_valid, s2_ready;
  s1_t                  s1;
  logic [PIX_W-1:0]     thr_r, thr_nxt;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  // threshold register, saturated on write
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_THRESHOLD);

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_wr) begin
      thr_nxt = (pwdata[PIX_W-1:0] > THRESH_MAX) ? THRESH_MAX : pwdata[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign prdata = (reg_idx == REG_THRESHOLD) ? CFG_DATA_W'(thr_r) : '0;

  // gray conversion front end
  fdfm_gray u_gray (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .s2_ready (s2_ready),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  // frame store compare and output stage
  fdfm_cmp u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s2_ready  (s2_ready),
    .threshold (thr_r),
    .out_res   (out_res)
  );

  `FDFM_ASSERT_NXT(a_threshold_in_range, cfg_wr, (thr_r <= THRESH_MAX) && (thr_r == $past(thr_nxt)))

endmodule

FILE: tb/sv/tb.sv
module tb;
  import fdfm_pkg::*;

  localparam int LATENCY      = 8;
  localparam int RESULT_WAIT  = 20000;
  localparam int LONG_HOLD    = 250;
  localparam int PHASE_PIXELS = 130;
  localparam int FIRST_FRAME  = 400;
  localparam int REG_UNMAPPED = 1;
  localparam int MAX_PRINTS   = 30;

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic             foreground;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
    logic             frame_done;
  } mask_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  fdfm_pix_if pix_ch ();
  fdfm_res_if res_ch ();

  frame_difference_foreground_mask dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_res (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // pending pixels and expected mask results
  pixel_t pixel_q[$];
  mask_t  mask_expect_q[$];

  // shadow of the block state
  bit [PIX_W-1:0] gray_store [MAX_PIXELS];
  int             store_pos = 0;
  bit             loading_first = 1'b1;
  bit [PIX_W-1:0] cfg_threshold = THRESH_RESET;

  // stimulus side memory of the last color sent at each position
  pixel_t last_color [MAX_PIXELS];
  int     gen_pos = 0;

  int err_count = 0;
  int results_seen = 0;

  // driver state
  pixel_t cur_pixel;
  int     burst_left = 0;
  int     gap_left = 0;

  // receiver state
  int hold_left = 0;
  int next_hold_at = 200;
  int pattern_left = 0;
  int stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #16000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(int idx, string field, int got, int want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("result %0d: %s is %0d, expected %0d", idx, field, got, want);
  endtask

  // gray conversion, frame store compare and write back for one accepted pixel
  task automatic track_pixel(pixel_t px);
    logic [31:0]    sum;
    bit [PIX_W-1:0] gray;
    bit [PIX_W-1:0] prev;
    bit [PIX_W-1:0] diff;
    mask_t          res;
    sum = 32'd1868 * px.blue + 32'd9617 * px.green + 32'd4899 * px.red + 32'd8192;
    gray = sum[21:14];
    prev = gray_store[store_pos];
    if (!loading_first) begin
      diff = (gray > prev) ? gray - prev : prev - gray;
      res.foreground = diff > cfg_threshold;
      res.blue = res.foreground ? px.blue : 8'hFF;
      res.green = res.foreground ? px.green : 8'hFF;
      res.red = res.foreground ? px.red : 8'hFF;
      res.frame_done = px.end_of_frame;
      mask_expect_q.push_back(res);
    end
    gray_store[store_pos] = gray;
    if (px.end_of_frame) begin
      store_pos = 0;
      loading_first = 1'b0;
    end else begin
      store_pos = (store_pos + 1 >= MAX_PIXELS) ? 0 : store_pos + 1;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 30);
  endfunction

  // driver: bursts of pixels with random gaps in between
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      if (pix_ch.valid && pix_ch.ready)
        track_pixel(cur_pixel);
      if (!pix_ch.valid || pix_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_ch.valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          cur_pixel = pixel_q.pop_front();
          pix_ch.valid <= 1'b1;
          pix_ch.blue <= cur_pixel.blue;
          pix_ch.green <= cur_pixel.green;
          pix_ch.red <= cur_pixel.red;
          pix_ch.end_of_frame <= cur_pixel.end_of_frame;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = pick_gap();
          end else begin
            burst_left--;
          end
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall pattern plus occasional long hold-offs
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else if (results_seen >= next_hold_at) begin
      hold_left <= LONG_HOLD;
      next_hold_at <= next_hold_at + 900;
      res_ch.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct <= 0;
          2: stall_pct <= 20;
          3: stall_pct <= 50;
          default: stall_pct <= 85;
        endcase
        pattern_left <= 63;
      end else begin
        pattern_left <= pattern_left - 1;
      end
      res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    mask_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (mask_expect_q.size() == 0) begin
        report_mismatch(results_seen, "unexpected transaction", 1, 0);
      end else begin
        want = mask_expect_q.pop_front();
        if (res_ch.foreground !== want.foreground)
          report_mismatch(results_seen, "foreground", res_ch.foreground, want.foreground);
        if (res_ch.out_blue !== want.blue)
          report_mismatch(results_seen, "out_blue", res_ch.out_blue, want.blue);
        if (res_ch.out_green !== want.green)
          report_mismatch(results_seen, "out_green", res_ch.out_green, want.green);
        if (res_ch.out_red !== want.red)
          report_mismatch(results_seen, "out_red", res_ch.out_red, want.red);
        if (res_ch.frame_done !== want.frame_done)
          report_mismatch(results_seen, "frame_done", res_ch.frame_done, want.frame_done);
      end
      results_seen <= results_seen + 1;
    end
  end

  // apb write: setup cycle then access cycle
  task automatic write_register(int idx, logic [31:0] value);
    bit [PIX_W-1:0] v;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    v = value[7:0];
    if (idx == int'(REG_THRESHOLD))
      cfg_threshold = (v > THRESH_MAX) ? THRESH_MAX : v;
  endtask

  // let all pixels go in and all results come out, then let the pipeline settle
  // checked between edges so the driver and monitor updates have landed
  task automatic wait_drained();
    int n;
    n = 0;
    while (pixel_q.size() != 0 || pix_ch.valid)
      @(negedge clk);
    while (mask_expect_q.size() != 0 && n < RESULT_WAIT) begin
      @(negedge clk);
      n++;
    end
    if (mask_expect_q.size() != 0) begin
      report_mismatch(results_seen, "missing transactions", 0, mask_expect_q.size());
      mask_expect_q.delete();
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic push_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic eof);
    pixel_t p;
    p = '{blue: b, green: g, red: r, end_of_frame: eof};
    pixel_q.push_back(p);
    last_color[gen_pos] = p;
    gen_pos = eof ? 0 : ((gen_pos + 1 >= MAX_PIXELS) ? 0 : gen_pos + 1);
  endtask

  function automatic logic [7:0] nudge(logic [7:0] c, int d);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * d)) - d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // mostly small changes from the previous frame so both mask values show up
  task automatic push_frame(int len);
    pixel_t last;
    int     mode;
    int     d;
    logic [7:0] b, g, r;
    for (int i = 0; i < len; i++) begin
      last = last_color[gen_pos];
      mode = $urandom_range(0, 9);
      d = (1 << $urandom_range(0, 4)) - 1;
      if (mode <= 4) begin
        b = nudge(last.blue, d);
        g = nudge(last.green, d);
        r = nudge(last.red, d);
      end else if (mode <= 7) begin
        b = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        r = 8'($urandom_range(0, 255));
      end else if (mode == 8) begin
        b = {8{1'($urandom_range(0, 1))}};
        g = {8{1'($urandom_range(0, 1))}};
        r = {8{1'($urandom_range(0, 1))}};
      end else begin
        b = last.blue;
        g = last.green;
        r = last.red;
      end
      push_pixel(b, g, r, i == len - 1);
    end
  endtask

  function automatic int pick_frame_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(100, 400);
    if (r <= 2) return 1;
    return $urandom_range(2, 48);
  endfunction

  initial begin
    int thresholds [8];
    int phase_count;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pix_ch.valid = 1'b0;
    pix_ch.blue = '0;
    pix_ch.green = '0;
    pix_ch.red = '0;
    pix_ch.end_of_frame = 1'b0;
    res_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // over-range threshold saturates; a write to an unmapped index changes nothing
    write_register(int'(REG_THRESHOLD), 32'hFFFF_FFFF);
    write_register(REG_UNMAPPED, 32'h0000_0000);

    // first frame fills every position that any later frame reaches
    for (int i = 0; i < FIRST_FRAME; i++)
      push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), i == FIRST_FRAME - 1);
    wait_drained();

    // full-scale swings at the top threshold, then an unchanged frame
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    for (int k = 0; k < 2; k++) begin
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    end
    wait_drained();

    // zero threshold: no change stays background, a one-step change is foreground
    write_register(int'(REG_THRESHOLD), {24'($urandom), 8'd0});
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hFF, 8'hFE, 8'hFF, 1'b1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    wait_drained();

    // random phases, each under its own threshold
    thresholds = '{251, 5, 250, 0, $urandom_range(0, 255), 255,
                   $urandom_range(0, 255), $urandom_range(0, 255)};
    foreach (thresholds[p]) begin
      write_register(int'(REG_THRESHOLD), {24'($urandom), 8'(thresholds[p])});
      phase_count = 0;
      while (phase_count < PHASE_PIXELS) begin
        int len;
        len = pick_frame_len();
        push_frame(len);
        phase_count += len;
      end
      wait_drained();
    end

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
